@@ design/ffra_pkg.sv @@
// ffra_pkg: shared types and constants for the first-fit range allocator
// holds the command codes, result status codes, table entry layout and controller states
// no dependencies
package ffra_pkg;

  localparam int TAG_W  = 31;
  localparam int HIGH_W = 32;

  localparam logic CMD_BOOK    = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOSPACE  = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // one booked range, half open [low, high)
  typedef struct packed {
    logic [TAG_W-1:0]  low;
    logic [HIGH_W-1:0] high;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BK_RD,
    S_BK_CHK,
    S_BK_SH_RD,
    S_BK_SH_WR,
    S_BK_PUT,
    S_RL_RD,
    S_RL_CHK,
    S_RL_SH_RD,
    S_RL_SH_WR,
    S_DONE
  } state_t;

endpackage

@@ design/ffra_in_if.sv @@
// ffra_in_if: request channel of the range allocator, valid/ready handshake
// carries command, request_count and release_start
// depends on ffra_pkg
interface ffra_in_if import ffra_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             command;
  logic [TAG_W-1:0] request_count;
  logic [TAG_W-1:0] release_start;

  modport source (output valid, command, request_count, release_start, input ready);
  modport sink   (input valid, command, request_count, release_start, output ready);
endinterface

@@ design/ffra_out_if.sv @@
// ffra_out_if: result channel of the range allocator, valid/ready handshake
// carries status and start_tag
// depends on ffra_pkg
interface ffra_out_if import ffra_pkg::*; ();
  logic             valid;
  logic             ready;
  status_t          status;
  logic [TAG_W-1:0] start_tag;

  modport source (output valid, status, start_tag, input ready);
  modport sink   (input valid, status, start_tag, output ready);
endinterface

@@ design/ffra_range_mem.sv @@
// ffra_range_mem: range table storage, one write port and one read port
// read data registered; depends on ffra_pkg
module ffra_range_mem import ffra_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/ffra_ctrl.sv @@
// ffra_ctrl: sequencer of the range allocator: gap scan, release lookup, table shifts
// owns the upper bound register, entry count and the result word register
// depends on ffra_pkg, drives the ports of ffra_range_mem
module ffra_ctrl import ffra_pkg::*; #(
  parameter int MAX_RANGES = 32,
  parameter int AW         = 5,
  parameter int CW         = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  // request word
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_command,
  input  logic [TAG_W-1:0] in_request_count,
  input  logic [TAG_W-1:0] in_release_start,
  // result word
  output logic             out_valid,
  input  logic             out_ready,
  output status_t          out_status,
  output logic [TAG_W-1:0] out_start_tag,
  // configuration
  input  logic             cfg_wr_en,
  input  logic [TAG_W-1:0] cfg_wr_data,
  // table memory
  output logic             mem_wr_en,
  output logic [AW-1:0]    mem_wr_addr,
  output entry_t           mem_wr_data,
  output logic [AW-1:0]    mem_rd_addr,
  input  entry_t           mem_rd_data
);

  state_t state_r, state_nxt;

  logic [TAG_W-1:0]  ub_r;
  logic [CW-1:0]     n_r, n_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [HIGH_W-1:0] lo_r, lo_nxt;
  logic [TAG_W-1:0]  key_r, key_nxt;   // request count or release start
  status_t           res_status_r, res_status_nxt;
  logic [TAG_W-1:0]  res_start_r, res_start_nxt;
  logic              out_valid_r;
  status_t           out_status_r;
  logic [TAG_W-1:0]  out_start_r;

  logic              at_end;
  logic              is_full;
  logic [TAG_W-1:0]  gap_hi;
  logic signed [HIGH_W+1:0] gap_size;
  logic              gap_fits;
  logic [CW-1:0]     idx_m1;
  logic [CW-1:0]     idx_p1;
  logic              accept;
  logic              out_free;

  assign at_end   = (idx_r == n_r);
  assign is_full  = (n_r == CW'(MAX_RANGES));
  assign idx_m1   = idx_r - CW'(1);
  assign idx_p1   = idx_r + CW'(1);
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // gap from the previous high up to the next low, or up to the bound past the last entry
  assign gap_hi   = (state_r == S_BK_RD) ? ub_r : mem_rd_data.low;
  assign gap_size = $signed({3'b000, gap_hi}) - $signed({2'b00, lo_r});
  assign gap_fits = gap_size >= $signed({3'b000, key_r});

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_command == CMD_BOOK) ? S_BK_RD : S_RL_RD;
        end
      end
      S_BK_RD: begin
        if (!at_end) begin
          state_nxt = S_BK_CHK;
        end else if (!gap_fits || is_full) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_BK_SH_RD;
        end
      end
      S_BK_CHK: begin
        if (!gap_fits) begin
          state_nxt = S_BK_RD;
        end else if (is_full) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_BK_SH_RD;
        end
      end
      S_BK_SH_RD: begin
        state_nxt = (idx_r == pos_r) ? S_BK_PUT : S_BK_SH_WR;
      end
      S_BK_SH_WR: state_nxt = S_BK_SH_RD;
      S_BK_PUT:   state_nxt = S_DONE;
      S_RL_RD: begin
        state_nxt = at_end ? S_DONE : S_RL_CHK;
      end
      S_RL_CHK: begin
        if (mem_rd_data.low < key_r) begin
          state_nxt = S_RL_RD;
        end else if (mem_rd_data.low == key_r) begin
          state_nxt = S_RL_SH_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RL_SH_RD: begin
        state_nxt = (idx_p1 >= n_r) ? S_DONE : S_RL_SH_WR;
      end
      S_RL_SH_WR: state_nxt = S_RL_SH_RD;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    n_nxt          = n_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    lo_nxt         = lo_r;
    key_nxt        = key_r;
    res_status_nxt = res_status_r;
    res_start_nxt  = res_start_r;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = idx_r[AW-1:0];
    mem_wr_data    = mem_rd_data;
    mem_rd_addr    = idx_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt        = '0;
          lo_nxt         = '0;
          res_status_nxt = ST_OK;
          res_start_nxt  = '0;
          key_nxt        = (in_command == CMD_BOOK) ? in_request_count : in_release_start;
        end
      end
      S_BK_RD: begin
        if (at_end) begin
          if (!gap_fits) begin
            res_status_nxt = ST_NOSPACE;
          end else if (is_full) begin
            res_status_nxt = ST_FULL;
          end else begin
            pos_nxt = idx_r;
          end
        end
      end
      S_BK_CHK: begin
        if (!gap_fits) begin
          lo_nxt  = mem_rd_data.high;
          idx_nxt = idx_p1;
        end else if (is_full) begin
          res_status_nxt = ST_FULL;
        end else begin
          pos_nxt = idx_r;
          idx_nxt = n_r;
        end
      end
      S_BK_SH_RD: begin
        mem_rd_addr = idx_m1[AW-1:0];
      end
      S_BK_SH_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = idx_r[AW-1:0];
        idx_nxt     = idx_m1;
      end
      S_BK_PUT: begin
        mem_wr_en        = 1'b1;
        mem_wr_addr      = pos_r[AW-1:0];
        mem_wr_data.low  = lo_r[TAG_W-1:0];
        mem_wr_data.high = lo_r + {1'b0, key_r};
        n_nxt            = n_r + CW'(1);
        res_start_nxt    = lo_r[TAG_W-1:0];
      end
      S_RL_RD: begin
        if (at_end) begin
          res_status_nxt = ST_NOTFOUND;
        end
      end
      S_RL_CHK: begin
        if (mem_rd_data.low < key_r) begin
          idx_nxt = idx_p1;
        end else if (mem_rd_data.low != key_r) begin
          res_status_nxt = ST_NOTFOUND;
        end
      end
      S_RL_SH_RD: begin
        mem_rd_addr = idx_p1[AW-1:0];
        if (idx_p1 >= n_r) begin
          n_nxt = n_r - CW'(1);
        end
      end
      S_RL_SH_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = idx_r[AW-1:0];
        idx_nxt     = idx_p1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= '0;
      ub_r        <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      if (cfg_wr_en) begin
        ub_r <= cfg_wr_data;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    lo_r         <= lo_nxt;
    key_r        <= key_nxt;
    res_status_r <= res_status_nxt;
    res_start_r  <= res_start_nxt;
    if (state_r == S_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_start_r  <= res_start_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_start_tag = out_start_r;

endmodule

@@ design/first_fit_range_allocator.sv @@
// First-fit range allocator.
// Request channel in_ch carries command (book or release), request_count and
// release_start; result channel out_ch returns one word per request: status and
// start_tag (start of the booked range, zero otherwise). Both use valid/ready,
// a word moves on a clock edge where both are high.
// cfg_wr_en/cfg_wr_data write the exclusive tag upper bound; write only while idle.
// Booked ranges live in a sorted table in a one-port-read, one-port-write memory.
// One request is worked at a time. A book reads entries one at a time until a gap
// fits, then moves every entry from the insert point up one place and writes the
// new range; with no fitting gap or a full table it reports no space or full instead.
// A release scans the same way and moves the entries after the match down one place,
// or reports not found. The next request is taken only once the controller is idle.
// The result sits in an output register, so a stalled receiver only holds the
// block once a second result is ready; the next request is taken meanwhile.
// Synchronous active-low reset empties the table and sets the bound to its maximum;
// no memory clearing pass is needed.
// Depends on ffra_pkg, ffra_in_if, ffra_out_if, ffra_range_mem, ffra_ctrl.
module first_fit_range_allocator import ffra_pkg::*; #(
  parameter int MAX_RANGES = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  ffra_in_if.sink          in_ch,
  ffra_out_if.source       out_ch,
  input  logic             cfg_wr_en,
  input  logic [TAG_W-1:0] cfg_wr_data
);

  localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CW = $clog2(MAX_RANGES + 1);

  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  entry_t        mem_wr_data;
  logic [AW-1:0] mem_rd_addr;
  entry_t        mem_rd_data;

  ffra_range_mem #(
    .DEPTH (MAX_RANGES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  ffra_ctrl #(
    .MAX_RANGES (MAX_RANGES),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_command       (in_ch.command),
    .in_request_count (in_ch.request_count),
    .in_release_start (in_ch.release_start),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_status       (out_ch.status),
    .out_start_tag    (out_ch.start_tag),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .mem_wr_en        (mem_wr_en),
    .mem_wr_addr      (mem_wr_addr),
    .mem_wr_data      (mem_wr_data),
    .mem_rd_addr      (mem_rd_addr),
    .mem_rd_data      (mem_rd_data)
  );

endmodule
